// File: rtl/arp_pending_frame_queue_assert.svh
// assertion macros used by the arp pending frame queue datapath
`ifndef ARP_PENDING_FRAME_QUEUE_ASSERT_SVH
`define ARP_PENDING_FRAME_QUEUE_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define APFQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define APFQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/apfq_pkg.sv
// ----------------------------------------------------------------------------
// apfq_pkg
// types shared by the controller and datapath of the pending frame queue
// ----------------------------------------------------------------------------
`default_nettype none

package apfq_pkg;

  typedef enum logic [1:0] {
    ACT_DELAY   = 2'd0,
    ACT_RESOLVE = 2'd1,
    ACT_TICK    = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    KIND_DELAY     = 2'd0,
    KIND_FWD       = 2'd1,
    KIND_RES_DONE  = 2'd2,
    KIND_TICK_DONE = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_T_RD,
    ST_T_CHK,
    ST_D_FIN,
    ST_R_START,
    ST_K_RD,
    ST_K_CHK,
    ST_Q_RD,
    ST_Q_CHK,
    ST_Q_END,
    ST_EMIT_DLY,
    ST_EMIT_DONE
  } state_e;

  localparam logic [15:0] TimeoutReset = 16'd1000;

  typedef struct packed {
    logic  latch_in;
    logic  idx_clr;
    logic  idx_inc;
    logic  found_set;
    logic  dly_fin;
    logic  tmr_clear;
    logic  tmr_tick;
    logic  q_keep;
    logic  q_drop;
    logic  q_commit;
    logic  out_load;
    kind_e out_kind;
  } cmd_t;

  typedef struct packed {
    action_e act;
    logic    full;
    logic    hit;
    logic    idx_last;
    logic    q_last;
    logic    q_empty;
    logic    found;
    logic    q_match;
    logic    out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/apfq_ram.sv
// ----------------------------------------------------------------------------
// apfq_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module apfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               we_i,
  input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                   wdata_i,
  input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                   rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/apfq_ctrl.sv
// ----------------------------------------------------------------------------
// apfq_ctrl
// sequencer for timer scans, queue compaction and result delivery
// ----------------------------------------------------------------------------
`default_nettype none

module apfq_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire apfq_pkg::sts_t  sts_i,
  output apfq_pkg::cmd_t       cmd_o
);

  apfq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= apfq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      apfq_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          unique case (apfq_pkg::action_e'(sts_i.act))
            apfq_pkg::ACT_DELAY:   state_d = sts_i.full ? apfq_pkg::ST_EMIT_DLY
                                                        : apfq_pkg::ST_T_RD;
            apfq_pkg::ACT_RESOLVE: state_d = apfq_pkg::ST_T_RD;
            apfq_pkg::ACT_TICK:    state_d = apfq_pkg::ST_K_RD;
            default:               state_d = apfq_pkg::ST_IDLE;
          endcase
        end
      end
      apfq_pkg::ST_T_RD: state_d = apfq_pkg::ST_T_CHK;
      apfq_pkg::ST_T_CHK: begin
        if (sts_i.hit || sts_i.idx_last) begin
          state_d = (sts_i.act == apfq_pkg::ACT_DELAY) ? apfq_pkg::ST_D_FIN
                                                        : apfq_pkg::ST_R_START;
        end else begin
          state_d = apfq_pkg::ST_T_RD;
        end
      end
      apfq_pkg::ST_D_FIN: state_d = apfq_pkg::ST_EMIT_DLY;
      apfq_pkg::ST_R_START: begin
        if (!sts_i.found) begin
          state_d = apfq_pkg::ST_EMIT_DONE;
        end else begin
          state_d = sts_i.q_empty ? apfq_pkg::ST_Q_END : apfq_pkg::ST_Q_RD;
        end
      end
      apfq_pkg::ST_K_RD: state_d = apfq_pkg::ST_K_CHK;
      apfq_pkg::ST_K_CHK: begin
        if (sts_i.idx_last) begin
          state_d = sts_i.q_empty ? apfq_pkg::ST_EMIT_DONE : apfq_pkg::ST_Q_RD;
        end else begin
          state_d = apfq_pkg::ST_K_RD;
        end
      end
      apfq_pkg::ST_Q_RD: state_d = apfq_pkg::ST_Q_CHK;
      apfq_pkg::ST_Q_CHK: begin
        if (!(sts_i.q_match && sts_i.act == apfq_pkg::ACT_RESOLVE && !sts_i.out_free)) begin
          state_d = sts_i.q_last ? apfq_pkg::ST_Q_END : apfq_pkg::ST_Q_RD;
        end
      end
      apfq_pkg::ST_Q_END: state_d = apfq_pkg::ST_EMIT_DONE;
      apfq_pkg::ST_EMIT_DLY: begin
        if (sts_i.out_free) begin
          state_d = apfq_pkg::ST_IDLE;
        end
      end
      apfq_pkg::ST_EMIT_DONE: begin
        if (sts_i.out_free) begin
          state_d = apfq_pkg::ST_IDLE;
        end
      end
      default: state_d = apfq_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    cmd_o.out_kind = apfq_pkg::KIND_DELAY;
    in_ready_o = 1'b0;
    unique case (state_q)
      apfq_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          cmd_o.idx_clr  = 1'b1;
        end
      end
      apfq_pkg::ST_T_RD: ;
      apfq_pkg::ST_T_CHK: begin
        cmd_o.found_set = sts_i.hit;
        if (!(sts_i.hit || sts_i.idx_last)) begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      apfq_pkg::ST_D_FIN: cmd_o.dly_fin = 1'b1;
      apfq_pkg::ST_R_START: begin
        if (sts_i.found) begin
          cmd_o.tmr_clear = 1'b1;
          cmd_o.idx_clr   = 1'b1;
        end
      end
      apfq_pkg::ST_K_RD: ;
      apfq_pkg::ST_K_CHK: begin
        cmd_o.tmr_tick = 1'b1;
        if (sts_i.idx_last) begin
          cmd_o.idx_clr = 1'b1;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      apfq_pkg::ST_Q_RD: ;
      apfq_pkg::ST_Q_CHK: begin
        if (sts_i.q_match) begin
          if (sts_i.act == apfq_pkg::ACT_RESOLVE) begin
            if (sts_i.out_free) begin
              cmd_o.out_load = 1'b1;
              cmd_o.out_kind = apfq_pkg::KIND_FWD;
              cmd_o.q_drop   = 1'b1;
              cmd_o.idx_inc  = !sts_i.q_last;
            end
          end else begin
            cmd_o.q_drop  = 1'b1;
            cmd_o.idx_inc = !sts_i.q_last;
          end
        end else begin
          cmd_o.q_keep  = 1'b1;
          cmd_o.idx_inc = !sts_i.q_last;
        end
      end
      apfq_pkg::ST_Q_END: cmd_o.q_commit = 1'b1;
      apfq_pkg::ST_EMIT_DLY: begin
        cmd_o.out_load = sts_i.out_free;
        cmd_o.out_kind = apfq_pkg::KIND_DELAY;
      end
      apfq_pkg::ST_EMIT_DONE: begin
        cmd_o.out_load = sts_i.out_free;
        cmd_o.out_kind = (sts_i.act == apfq_pkg::ACT_TICK) ? apfq_pkg::KIND_TICK_DONE
                                                            : apfq_pkg::KIND_RES_DONE;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/apfq_dp.sv
// ----------------------------------------------------------------------------
// apfq_dp
// frame queue and timer storage, scan index, counters and output register
// ----------------------------------------------------------------------------
`default_nettype none

module apfq_dp #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [15:0]     cfg_wdata_i,
  input  wire logic [1:0]      action_i,
  input  wire logic [31:0]     hop_addr_i,
  input  wire logic [15:0]     frame_tag_i,
  input  wire logic [47:0]     eth_addr_i,
  input  wire apfq_pkg::cmd_t  cmd_i,
  output apfq_pkg::sts_t       sts_o,
  input  wire logic            out_ready_i,
  output logic                 out_valid_o,
  output logic [1:0]           kind_o,
  output logic                 accepted_o,
  output logic                 timer_started_o,
  output logic [15:0]          out_tag_o,
  output logic [31:0]          out_hop_o,
  output logic [47:0]          out_eth_o,
  output logic [4:0]           frame_count_o,
  output logic                 last_o
);

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int TW = 48;
  localparam int QW = 48 + IW;

  logic [1:0]  act_q;
  logic [31:0] hop_q;
  logic [15:0] tag_q;
  logic [47:0] eth_q;
  logic [15:0] timeout_q;

  logic [IW-1:0] idx_q, slot_q;
  logic [CW-1:0] count_q, keep_q, cnt_q;
  logic          found_q, acc_q, ts_q;
  logic [QUEUE_DEPTH-1:0] valid_q, gone_q;

  logic [TW-1:0] t_rdata, t_wdata;
  logic [IW-1:0] t_waddr;
  logic          t_we;
  logic [31:0]   t_hop;
  logic [15:0]   t_left;

  logic [QW-1:0] q_rdata, q_wdata;
  logic [IW-1:0] q_waddr;
  logic          q_we;
  logic [31:0]   q_hop;
  logic [15:0]   q_tag;
  logic [IW-1:0] q_slot;

  logic [IW-1:0] free_idx;
  logic          free_any;
  logic          out_free;
  logic          expire;
  logic [4:0]    fc_sat;

  assign t_hop  = t_rdata[47:16];
  assign t_left = t_rdata[15:0];
  assign q_hop  = q_rdata[QW-1 -: 32];
  assign q_tag  = q_rdata[IW +: 16];
  assign q_slot = q_rdata[IW-1:0];

  apfq_ram #(.WIDTH(TW), .DEPTH(QUEUE_DEPTH)) u_tmr_ram (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (t_waddr),
    .wdata_i (t_wdata),
    .raddr_i (idx_q),
    .rdata_o (t_rdata)
  );

  apfq_ram #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_q_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .raddr_i (idx_q),
    .rdata_o (q_rdata)
  );

  // lowest free timer slot
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = IW'(i);
        free_any = 1'b1;
      end
    end
  end

  assign out_free = !out_valid_o || out_ready_i;
  assign expire   = valid_q[idx_q] && (t_left <= 16'd1);

  always_comb begin
    sts_o.act      = apfq_pkg::action_e'(cmd_i.latch_in ? action_i : act_q);
    sts_o.full     = count_q >= CW'(QUEUE_DEPTH);
    sts_o.hit      = valid_q[idx_q] && (t_hop == hop_q);
    sts_o.idx_last = idx_q == IW'(QUEUE_DEPTH - 1);
    sts_o.q_last   = (CW'(idx_q) + CW'(1)) == count_q;
    sts_o.q_empty  = count_q == '0;
    sts_o.found    = found_q;
    sts_o.q_match  = (act_q == apfq_pkg::ACT_RESOLVE) ? (q_hop == hop_q) : gone_q[q_slot];
    sts_o.out_free = out_free;
  end

  // storage write ports
  always_comb begin
    t_we    = 1'b0;
    t_waddr = idx_q;
    t_wdata = {t_hop, t_left - 16'd1};
    if (cmd_i.dly_fin && !found_q && free_any) begin
      t_we    = 1'b1;
      t_waddr = free_idx;
      t_wdata = {hop_q, timeout_q};
    end else if (cmd_i.tmr_tick && valid_q[idx_q] && !expire) begin
      t_we = 1'b1;
    end
  end

  always_comb begin
    q_we    = 1'b0;
    q_waddr = keep_q[IW-1:0];
    q_wdata = q_rdata;
    if (cmd_i.dly_fin && (found_q || free_any)) begin
      q_we    = 1'b1;
      q_waddr = count_q[IW-1:0];
      q_wdata = {hop_q, tag_q, found_q ? slot_q : free_idx};
    end else if (cmd_i.q_keep) begin
      q_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      hop_q <= hop_addr_i;
      tag_q <= frame_tag_i;
      eth_q <= eth_addr_i;
    end
    if (cmd_i.found_set) begin
      slot_q <= idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q     <= apfq_pkg::ACT_NONE;
      timeout_q <= apfq_pkg::TimeoutReset;
      idx_q     <= '0;
      count_q   <= '0;
      keep_q    <= '0;
      cnt_q     <= '0;
      found_q   <= 1'b0;
      acc_q     <= 1'b0;
      ts_q      <= 1'b0;
      valid_q   <= '0;
      gone_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      if (cmd_i.latch_in) begin
        act_q   <= action_i;
        found_q <= 1'b0;
        acc_q   <= 1'b0;
        ts_q    <= 1'b0;
        keep_q  <= '0;
        cnt_q   <= '0;
        gone_q  <= '0;
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + IW'(1);
      end
      if (cmd_i.found_set) begin
        found_q <= 1'b1;
      end
      if (cmd_i.dly_fin) begin
        if (found_q) begin
          count_q <= count_q + CW'(1);
          acc_q   <= 1'b1;
        end else if (free_any) begin
          valid_q[free_idx] <= 1'b1;
          count_q <= count_q + CW'(1);
          acc_q   <= 1'b1;
          ts_q    <= 1'b1;
        end
      end
      if (cmd_i.tmr_clear) begin
        valid_q[slot_q] <= 1'b0;
      end
      if (cmd_i.tmr_tick && expire) begin
        valid_q[idx_q] <= 1'b0;
        gone_q[idx_q]  <= 1'b1;
      end
      if (cmd_i.q_keep) begin
        keep_q <= keep_q + CW'(1);
      end
      if (cmd_i.q_drop) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (cmd_i.q_commit) begin
        count_q <= keep_q;
      end
    end
  end

  // count field saturates at 31
  always_comb begin
    int c;
    c = int'(cnt_q);
    fc_sat = (c > 31) ? 5'd31 : 5'(c);
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      kind_o          <= cmd_i.out_kind;
      accepted_o      <= 1'b0;
      timer_started_o <= 1'b0;
      out_tag_o       <= '0;
      out_hop_o       <= '0;
      out_eth_o       <= '0;
      frame_count_o   <= '0;
      last_o          <= 1'b1;
      unique case (cmd_i.out_kind)
        apfq_pkg::KIND_DELAY: begin
          accepted_o      <= acc_q;
          timer_started_o <= ts_q;
        end
        apfq_pkg::KIND_FWD: begin
          out_tag_o <= q_tag;
          out_hop_o <= hop_q;
          out_eth_o <= eth_q;
          last_o    <= 1'b0;
        end
        apfq_pkg::KIND_RES_DONE,
        apfq_pkg::KIND_TICK_DONE: frame_count_o <= fc_sat;
        default: ;
      endcase
    end
  end

  `include "arp_pending_frame_queue_assert.svh"

  `APFQ_ASSERT(a_out_no_overwrite, cmd_i.out_load |-> out_free, "result overwritten")
  `APFQ_ASSERT(a_count_bound, count_q <= CW'(QUEUE_DEPTH), "queue count beyond depth")
  `APFQ_ASSERT(a_keep_behind, cmd_i.q_keep |-> (keep_q <= CW'(idx_q)), "compaction ahead of read")
  `APFQ_ASSERT_NEXT(a_alloc_valid, cmd_i.dly_fin && !found_q && free_any,
                    valid_q[$past(free_idx)], "allocated timer not valid")

endmodule

`default_nettype wire

// File: rtl/arp_pending_frame_queue.sv
// ----------------------------------------------------------------------------
// arp_pending_frame_queue: frames waiting for address resolution, with timers
// delay scans the timer slots and stops at a hit; resolve does the same scan, then
// on a hit walks the queued frames; tick walks every slot, then the queue; one item at a time in ram
// reset: queue empty, all timers idle, timeout_ticks 1000, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module arp_pending_frame_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration: timeout_ticks
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  // input words
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [31:0] hop_addr_i,
  input  wire logic [15:0] frame_tag_i,
  input  wire logic [47:0] eth_addr_i,
  // result words
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       kind_o,
  output logic             accepted_o,
  output logic             timer_started_o,
  output logic [15:0]      out_tag_o,
  output logic [31:0]      out_hop_o,
  output logic [47:0]      out_eth_o,
  output logic [4:0]       frame_count_o,
  output logic             last_o
);

  // the controller walks the timer ram and the queue ram through one shared
  // index; each queue entry carries its timer slot so a tick drops frames
  // by looking up the expired mark of that slot, no second search
  apfq_pkg::cmd_t cmd;
  apfq_pkg::sts_t sts;

  apfq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: storage, counters and the output register that lets a new
  // word be taken while a result still waits
  apfq_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .action_i        (action_i),
    .hop_addr_i      (hop_addr_i),
    .frame_tag_i     (frame_tag_i),
    .eth_addr_i      (eth_addr_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .kind_o          (kind_o),
    .accepted_o      (accepted_o),
    .timer_started_o (timer_started_o),
    .out_tag_o       (out_tag_o),
    .out_hop_o       (out_hop_o),
    .out_eth_o       (out_eth_o),
    .frame_count_o   (frame_count_o),
    .last_o          (last_o)
  );

endmodule

`default_nettype wire

// File: dv/arp_pending_frame_queue_tb.sv
// ----------------------------------------------------------------------------
// arp_pending_frame_queue_tb
// self-checking bench for the pending frame queue: a queue-fed driver pushes
// delay, resolve, tick and unused-action words, an in-bench predictor of the frame fifo and
// timers builds the expected result words, and a monitor checks every field
// ----------------------------------------------------------------------------
`default_nettype none

module arp_pending_frame_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth      = 16;
  localparam int CycleLimit = 300000;
  localparam int SettleCyc  = 100;   // drain wait, longer than the worst-case resolve/tick walk

  typedef struct {
    apfq_pkg::action_e act;
    logic [31:0]       hop;
    logic [15:0]       tag;
    logic [47:0]       eth;
  } arp_word_t;

  typedef struct {
    apfq_pkg::kind_e kind;
    logic            acc;
    logic            started;
    logic [15:0]     tag;
    logic [31:0]     hop;
    logic [47:0]     eth;
    logic [4:0]      cnt;
    logic            last;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  action_i = '0;
  logic [31:0] hop_addr_i = '0;
  logic [15:0] frame_tag_i = '0;
  logic [47:0] eth_addr_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  kind_o;
  logic        accepted_o;
  logic        timer_started_o;
  logic [15:0] out_tag_o;
  logic [31:0] out_hop_o;
  logic [47:0] out_eth_o;
  logic [4:0]  frame_count_o;
  logic        last_o;

  arp_pending_frame_queue #(.QUEUE_DEPTH(Depth)) DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .action_i, .hop_addr_i, .frame_tag_i, .eth_addr_i,
    .out_valid_o, .out_ready_i, .kind_o, .accepted_o, .timer_started_o,
    .out_tag_o, .out_hop_o, .out_eth_o, .frame_count_o, .last_o
  );

  // words waiting to be driven, expected answers in arrival order
  arp_word_t send_q[$];
  answer_t   answer_q[$];

  // predicted block state
  logic [31:0] fifo_hop[Depth];
  logic [15:0] fifo_tag[Depth];
  int          fifo_len;
  logic        tmr_on[Depth];
  logic [31:0] tmr_hop[Depth];
  logic [15:0] tmr_left[Depth];
  logic [15:0] timeout_cfg;

  int  cycle_cnt;
  int  fail_cnt;
  int  result_cnt;
  int  hold_left;
  bit  hold_done;
  logic [31:0] hop_pool[5];

  initial forever #4 clk_i = ~clk_i;

  // no random idling inside this window so back-to-back traffic also runs
  function automatic bit quiet_window();
    return cycle_cnt >= 3000 && cycle_cnt < 9000;
  endfunction

  function automatic void push_answer(apfq_pkg::kind_e k, logic acc, logic st,
                                      logic [15:0] tag, logic [31:0] hop,
                                      logic [47:0] eth, int cnt, logic last);
    answer_t a;
    a.kind = k; a.acc = acc; a.started = st; a.tag = tag; a.hop = hop; a.eth = eth;
    a.cnt = (cnt > 31) ? 5'd31 : cnt[4:0];
    a.last = last;
    answer_q.push_back(a);
  endfunction

  function automatic int timer_of(logic [31:0] hop);
    for (int i = 0; i < Depth; i++)
      if (tmr_on[i] && tmr_hop[i] == hop) return i;
    return -1;
  endfunction

  // predictor: update fifo/timers for one accepted word, queue its answers
  function automatic void resolve_frames(arp_word_t w);
    int slot;
    int keep;
    int cnt;
    bit gone[Depth];
    bit drop;
    case (w.act)
      apfq_pkg::ACT_DELAY: begin
        if (fifo_len >= Depth) begin
          push_answer(apfq_pkg::KIND_DELAY, 0, 0, '0, '0, '0, 0, 1);
          return;
        end
        slot = timer_of(w.hop);
        if (slot < 0) begin
          for (int i = Depth - 1; i >= 0; i--)
            if (!tmr_on[i]) slot = i;
          if (slot < 0) begin
            push_answer(apfq_pkg::KIND_DELAY, 0, 0, '0, '0, '0, 0, 1);
            return;
          end
          tmr_on[slot] = 1; tmr_hop[slot] = w.hop; tmr_left[slot] = timeout_cfg;
          drop = 1;
        end else begin
          drop = 0;
        end
        fifo_hop[fifo_len] = w.hop;
        fifo_tag[fifo_len] = w.tag;
        fifo_len++;
        push_answer(apfq_pkg::KIND_DELAY, 1, drop, '0, '0, '0, 0, 1);
      end
      apfq_pkg::ACT_RESOLVE: begin
        slot = timer_of(w.hop);
        cnt = 0;
        if (slot >= 0) begin
          tmr_on[slot] = 0;
          keep = 0;
          for (int i = 0; i < fifo_len; i++) begin
            if (fifo_hop[i] == w.hop) begin
              push_answer(apfq_pkg::KIND_FWD, 0, 0, fifo_tag[i], w.hop, w.eth, 0, 0);
              cnt++;
            end else begin
              fifo_hop[keep] = fifo_hop[i];
              fifo_tag[keep] = fifo_tag[i];
              keep++;
            end
          end
          fifo_len = keep;
        end
        push_answer(apfq_pkg::KIND_RES_DONE, 0, 0, '0, '0, '0, cnt, 1);
      end
      apfq_pkg::ACT_TICK: begin
        for (int i = 0; i < Depth; i++) begin
          gone[i] = 0;
          if (tmr_on[i]) begin
            // a zero timeout expires on the first tick, same as one
            if (tmr_left[i] <= 1) begin
              gone[i] = 1;
              tmr_on[i] = 0;
            end else begin
              tmr_left[i]--;
            end
          end
        end
        cnt = 0;
        keep = 0;
        for (int i = 0; i < fifo_len; i++) begin
          drop = 0;
          for (int j = 0; j < Depth; j++)
            if (gone[j] && tmr_hop[j] == fifo_hop[i]) drop = 1;
          if (drop) begin
            cnt++;
          end else begin
            fifo_hop[keep] = fifo_hop[i];
            fifo_tag[keep] = fifo_tag[i];
            keep++;
          end
        end
        fifo_len = keep;
        push_answer(apfq_pkg::KIND_TICK_DONE, 0, 0, '0, '0, '0, cnt, 1);
      end
      default: ;  // unused action: no state change, no answer
    endcase
  endfunction

  function automatic void check_field(string name, logic [47:0] exp_v, logic [47:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s expected %0h got %0h", name, exp_v, act_v);
      fail_cnt++;
    end
  endfunction

  // driver: hold the word until accepted, then load the next one or idle
  always @(posedge clk_i) begin
    arp_word_t w;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        w.act = apfq_pkg::action_e'(action_i); w.hop = hop_addr_i;
        w.tag = frame_tag_i; w.eth = eth_addr_i;
        resolve_frames(w);
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_q.size() > 0 && (quiet_window() || $urandom_range(99) >= 9)) begin
          w = send_q.pop_front();
          action_i    <= w.act;
          hop_addr_i  <= w.hop;
          frame_tag_i <= w.tag;
          eth_addr_i  <= w.eth;
          in_valid_i  <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure plus one long hold-off so the block fills up
  always @(posedge clk_i) begin
    answer_t a;
    if (rst_ni) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > CycleLimit) begin
        $display("arp_pending_frame_queue regression: fail");
        $finish;
      end
      if (out_valid_o && out_ready_i) begin
        result_cnt <= result_cnt + 1;
        if (answer_q.size() == 0) begin
          $error("unexpected result word, kind %0d", kind_o);
          fail_cnt++;
        end else begin
          a = answer_q.pop_front();
          check_field("kind", 48'(a.kind), 48'(kind_o));
          check_field("accepted", 48'(a.acc), 48'(accepted_o));
          check_field("timer_started", 48'(a.started), 48'(timer_started_o));
          check_field("out_tag", 48'(a.tag), 48'(out_tag_o));
          check_field("out_hop", 48'(a.hop), 48'(out_hop_o));
          check_field("out_eth", a.eth, out_eth_o);
          check_field("frame_count", 48'(a.cnt), 48'(frame_count_o));
          check_field("last", 48'(a.last), 48'(last_o));
        end
      end
      if (!hold_done && result_cnt == 40) begin
        hold_done <= 1'b1;
        hold_left <= 400;
        out_ready_i <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= quiet_window() || $urandom_range(99) >= 9;
      end
    end
  end

  function automatic void add_word(apfq_pkg::action_e act, logic [31:0] hop,
                                   logic [15:0] tag, logic [47:0] eth);
    arp_word_t w;
    w.act = act; w.hop = hop; w.tag = tag; w.eth = eth;
    send_q.push_back(w);
  endfunction

  function automatic logic [47:0] rand_eth();
    return 48'({$urandom, $urandom});
  endfunction

  // sender pauses until every word is in and every answer is out
  task automatic drain();
    while (send_q.size() != 0 || in_valid_i || answer_q.size() != 0) begin
      @(posedge clk_i);
      #1;
    end
    // an unused action has no answer and does not keep the block busy
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic set_timeout(logic [15:0] ticks);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= ticks;
    timeout_cfg = ticks;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_phase(int n_items);
    int r;
    int made;
    for (int i = 0; i < 5; i++)
      hop_pool[i] = ($urandom_range(7) == 0) ? {32{i[0]}} : $urandom;
    made = 0;
    while (made < n_items) begin
      r = $urandom_range(99);
      if (r < 50) begin
        add_word(apfq_pkg::ACT_DELAY, hop_pool[$urandom_range(4)], 16'($urandom),
                 rand_eth());
      end else if (r < 70) begin
        add_word(apfq_pkg::ACT_RESOLVE,
                 ($urandom_range(7) == 0) ? $urandom : hop_pool[$urandom_range(4)],
                 16'($urandom), rand_eth());
      end else if (r < 97) begin
        add_word(apfq_pkg::ACT_TICK, $urandom, 16'($urandom), rand_eth());
      end else begin
        add_word(apfq_pkg::ACT_NONE, $urandom, 16'($urandom), rand_eth());
        made--;  // ignored words don't count
      end
      made++;
    end
  endtask

  initial begin
    logic [15:0] timeouts[6] = '{16'd1, 16'd3, 16'd0, 16'd65535, 16'd2, 16'd5};
    fifo_len = 0;
    timeout_cfg = apfq_pkg::TimeoutReset;
    for (int i = 0; i < Depth; i++) begin
      tmr_on[i] = 0; tmr_hop[i] = '0; tmr_left[i] = '0;
      fifo_hop[i] = '0; fifo_tag[i] = '0;
    end
    cycle_cnt = 0; fail_cnt = 0; result_cnt = 0; hold_left = 0; hold_done = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: shared timer, double resolve, unmatched resolve, idle tick,
    // unused action, queue full refusal, extreme field values
    add_word(apfq_pkg::ACT_DELAY, 32'h0, 16'h0, 48'h0);
    add_word(apfq_pkg::ACT_DELAY, 32'h0, 16'hFFFF, 48'h0);
    add_word(apfq_pkg::ACT_DELAY, 32'hFFFF_FFFF, 16'h1234, 48'h0);
    add_word(apfq_pkg::ACT_RESOLVE, 32'h0, 16'h0, 48'hFFFF_FFFF_FFFF);
    add_word(apfq_pkg::ACT_RESOLVE, 32'h0, 16'h0, 48'h1);
    add_word(apfq_pkg::ACT_RESOLVE, 32'h5555_AAAA, 16'h0, 48'hAAAA_5555_AAAA);
    add_word(apfq_pkg::ACT_TICK, 32'h0, 16'h0, 48'h0);
    add_word(apfq_pkg::ACT_NONE, 32'hFFFF_FFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
    for (int i = 1; i <= 16; i++)
      add_word(apfq_pkg::ACT_DELAY, 32'h0A00_0000 + i, 16'(i), 48'h0);
    add_word(apfq_pkg::ACT_RESOLVE, 32'hFFFF_FFFF, 16'h0, 48'h0);
    drain();

    for (int p = 0; p < 6; p++) begin
      set_timeout(timeouts[p]);
      random_phase(23);
      drain();
    end

    if (fail_cnt == 0) begin
      $display("arp_pending_frame_queue regression: pass");
    end else begin
      $display("arp_pending_frame_queue regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
+incdir+rtl
rtl/apfq_pkg.sv
rtl/apfq_ram.sv
rtl/apfq_ctrl.sv
rtl/apfq_dp.sv
rtl/arp_pending_frame_queue.sv
dv/arp_pending_frame_queue_tb.sv
